// ----- rtl/kec_pkg.sv -----
// Shared types and constants for the Kruskal edge classifier.
`default_nettype none

package kec_pkg;

    localparam int VERTEX_W = 10;

    localparam logic FUNC_CLASSIFY = 1'b0;
    localparam logic FUNC_CLEAR    = 1'b1;

    typedef struct packed {
        logic                func;
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
    } edge_item_t;

    typedef struct packed {
        logic edge_in_forest;
        logic cleared;
    } result_item_t;

endpackage

`default_nettype wire

// ----- rtl/kec_parent_ram.sv -----
// Parent store: one write port and one read port with registered read data.
`default_nettype none

module kec_parent_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [AW-1:0] wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [AW-1:0] rd_data
);

    logic [AW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/kruskal_edge_classifier_unit.sv -----
// Top level of the Kruskal edge classifier: sequencer, shared compare unit and parent store.
//
//   channel   dir  handshake                  payload
//   edge      in   edge_valid / edge_stall    kec_pkg::edge_item_t
//   result    out  result_valid / result_stall kec_pkg::result_item_t
//
// A classify transfer reduces each endpoint modulo NODES by shifted subtraction (skipped when
// NODES is at least 1024), then walks the parent links from that endpoint to its root through
// the memory read port and, if the two roots differ, links the second root under the first.
// A clear transfer rewrites the store one entry per cycle.
// After reset the store is swept while edge_stall stays high.
// A finished result waits in the output register while the next edge is accepted.
`default_nettype none

module kruskal_edge_classifier_unit #(
    parameter int NODES = 1024
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   edge_valid,
    output logic                        edge_stall,
    input  wire kec_pkg::edge_item_t    edge_item,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output kec_pkg::result_item_t       result_item
);

    localparam int IW        = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int RW        = kec_pkg::VERTEX_W + 1;
    localparam int CW        = (RW > IW) ? RW : IW;
    localparam bit NEED_RED  = NODES < (2 ** kec_pkg::VERTEX_W);
    localparam int RED_STEPS = NEED_RED ? (kec_pkg::VERTEX_W - IW + 1) : 1;
    localparam int SHW       = $clog2(kec_pkg::VERTEX_W + 1);

    typedef enum logic [6:0] {
        S_SWEEP  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_REDUCE = 7'b0000100,
        S_LOAD   = 7'b0001000,
        S_WALK   = 7'b0010000,
        S_LINK   = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t                 state_reg, state_next;
    kec_pkg::edge_item_t    item_reg, item_next;
    logic                   phase_reg, phase_next;
    logic [RW-1:0]          red_reg, red_next;
    logic [SHW-1:0]         shift_reg, shift_next;
    logic [IW-1:0]          cur_reg, cur_next;
    logic [IW-1:0]          root_a_reg, root_a_next;
    logic [IW-1:0]          sweep_reg, sweep_next;
    logic                   clear_cmd_reg, clear_cmd_next;
    logic                   kept_reg, kept_next;
    logic                   result_valid_reg, result_valid_next;
    kec_pkg::result_item_t  result_reg, result_next;

    logic [CW-1:0] op_a;
    logic [CW-1:0] op_b;
    logic [CW-1:0] diff;
    logic          op_eq;
    logic          op_ge;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [IW-1:0] wr_data;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] rd_data;

    logic edge_take;

    kec_parent_ram #(
        .DEPTH (NODES),
        .AW    (IW)
    ) u_parent_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign diff  = op_a - op_b;
    assign op_eq = (op_a == op_b);
    assign op_ge = (op_a >= op_b);

    assign edge_stall   = (state_reg != S_IDLE);
    assign edge_take    = edge_valid && !edge_stall;
    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;

    always_comb
    begin
        state_next        = state_reg;
        item_next         = item_reg;
        phase_next        = phase_reg;
        red_next          = red_reg;
        shift_next        = shift_reg;
        cur_next          = cur_reg;
        root_a_next       = root_a_reg;
        sweep_next        = sweep_reg;
        clear_cmd_next    = clear_cmd_reg;
        kept_next         = kept_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        op_a              = CW'(cur_reg);
        op_b              = CW'(cur_reg);
        wr_en             = 1'b0;
        wr_addr           = sweep_reg;
        wr_data           = sweep_reg;
        rd_addr           = cur_reg;

        unique case (state_reg)
            S_SWEEP:
            begin
                wr_en   = 1'b1;
                wr_addr = sweep_reg;
                wr_data = sweep_reg;
                op_a    = CW'(sweep_reg);
                op_b    = CW'(NODES - 1);
                if (op_eq)
                begin
                    state_next = clear_cmd_reg ? S_DONE : S_IDLE;
                    kept_next  = 1'b0;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (edge_take)
                begin
                    item_next = edge_item;
                    if (edge_item.func == kec_pkg::FUNC_CLEAR)
                    begin
                        sweep_next     = '0;
                        clear_cmd_next = 1'b1;
                        state_next     = S_SWEEP;
                    end
                    else
                    begin
                        clear_cmd_next = 1'b0;
                        phase_next     = 1'b0;
                        red_next       = RW'(edge_item.vertex_a);
                        shift_next     = SHW'(RED_STEPS - 1);
                        state_next     = NEED_RED ? S_REDUCE : S_LOAD;
                    end
                end
            end
            S_REDUCE:
            begin
                op_a = CW'(red_reg);
                op_b = CW'(NODES) << shift_reg;
                if (op_ge)
                begin
                    red_next = RW'(diff);
                end
                if (shift_reg == '0)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    shift_next = shift_reg - 1'b1;
                end
            end
            S_LOAD:
            begin
                rd_addr    = IW'(red_reg);
                cur_next   = IW'(red_reg);
                state_next = S_WALK;
            end
            S_WALK:
            begin
                op_a = CW'(rd_data);
                op_b = CW'(cur_reg);
                if (op_eq)
                begin
                    if (!phase_reg)
                    begin
                        root_a_next = cur_reg;
                        phase_next  = 1'b1;
                        red_next    = RW'(item_reg.vertex_b);
                        shift_next  = SHW'(RED_STEPS - 1);
                        state_next  = NEED_RED ? S_REDUCE : S_LOAD;
                    end
                    else
                    begin
                        state_next = S_LINK;
                    end
                end
                else
                begin
                    cur_next = rd_data;
                    rd_addr  = rd_data;
                end
            end
            S_LINK:
            begin
                op_a    = CW'(root_a_reg);
                op_b    = CW'(cur_reg);
                wr_addr = cur_reg;
                wr_data = root_a_reg;
                wr_en   = !op_eq;
                kept_next  = !op_eq;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next          = 1'b1;
                    result_next.edge_in_forest = kept_reg;
                    result_next.cleared        = clear_cmd_reg;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_SWEEP;
            sweep_reg        <= '0;
            clear_cmd_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sweep_reg        <= sweep_next;
            clear_cmd_reg    <= clear_cmd_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        phase_reg  <= phase_next;
        red_reg    <= red_next;
        shift_reg  <= shift_next;
        cur_reg    <= cur_next;
        root_a_reg <= root_a_next;
        kept_reg   <= kept_next;
        result_reg <= result_next;
    end

endmodule

`default_nettype wire

// ----- rtl/kec_checker.sv -----
// Port-level checker for the Kruskal edge classifier and its bind to the top level.
`default_nettype none

module kec_checker (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  edge_valid,
    input wire logic                  edge_stall,
    input wire kec_pkg::edge_item_t   edge_item,
    input wire logic                  result_valid,
    input wire logic                  result_stall,
    input wire kec_pkg::result_item_t result_item
);

    // A stalled result stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_item))
    else $error("stalled result changed or was dropped");

    // A stalled edge stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        edge_valid && edge_stall |=> edge_valid && $stable(edge_item))
    else $error("stalled edge changed or was dropped");

    // The block works on one edge at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        edge_valid && !edge_stall |=> edge_stall)
    else $error("edge accepted while the previous one is still in work");

    // No result can appear in the cycle right after an edge transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        edge_valid && !edge_stall |=> !$rose(result_valid))
    else $error("result appeared too early after an edge transfer");

    // A clear acknowledgment never reports a kept edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result_item.cleared && result_item.edge_in_forest))
    else $error("clear acknowledgment marked as a kept edge");

endmodule

bind kruskal_edge_classifier_unit kec_checker u_kec_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .edge_valid   (edge_valid),
    .edge_stall   (edge_stall),
    .edge_item    (edge_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
);

`default_nettype wire

// ----- bench/kec_forest_checker.sv -----
`timescale 1ns / 100ps
// Checker that predicts the edge classifier's results with its own union-find store and compares them.
module kec_forest_checker #(
    parameter int NODES = 1024
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  edge_valid,
    input  wire logic                  edge_stall,
    input  wire kec_pkg::edge_item_t   edge_item,
    input  wire logic                  result_valid,
    input  wire logic                  result_stall,
    input  wire kec_pkg::result_item_t result_item,
    output int                         errors,
    output int                         pending
);

    int unsigned            parent_of_node [NODES];
    kec_pkg::result_item_t  expected_results [$];

    function automatic void reset_forest();
        for (int n = 0; n < NODES; n++)
            parent_of_node[n] = n;
    endfunction

    function automatic int unsigned find_root(input int unsigned node);
        int unsigned cur;
        int unsigned up;
        cur = node;
        for (int unsigned steps = 0; steps < NODES; steps++)
        begin
            up = parent_of_node[cur];
            if (up >= NODES || up == cur)
                break;
            cur = up;
        end
        return cur;
    endfunction

    function automatic kec_pkg::result_item_t apply_edge_item(input kec_pkg::edge_item_t it);
        kec_pkg::result_item_t res;
        int unsigned           root_a;
        int unsigned           root_b;
        res = '0;
        if (it.func == kec_pkg::FUNC_CLEAR)
        begin
            reset_forest();
            res.cleared = 1'b1;
        end
        else
        begin
            root_a = find_root(int'(it.vertex_a) % NODES);
            root_b = find_root(int'(it.vertex_b) % NODES);
            if (root_a != root_b)
            begin
                parent_of_node[root_b] = root_a;
                res.edge_in_forest = 1'b1;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        kec_pkg::result_item_t expected;
        int                    fails;
        if (!rst_n)
        begin
            reset_forest();
            expected_results.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            fails = 0;
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result transfer: expected none, actual %b",
                             $time, result_item);
                    fails++;
                end
                else
                begin
                    expected = expected_results.pop_front();
                    if (result_item.edge_in_forest !== expected.edge_in_forest)
                    begin
                        $display("%0t: edge_in_forest mismatch: expected %b, actual %b",
                                 $time, expected.edge_in_forest, result_item.edge_in_forest);
                        fails++;
                    end
                    if (result_item.cleared !== expected.cleared)
                    begin
                        $display("%0t: cleared mismatch: expected %b, actual %b",
                                 $time, expected.cleared, result_item.cleared);
                        fails++;
                    end
                end
            end
            if (edge_valid && !edge_stall)
                expected_results.push_back(apply_edge_item(edge_item));
            errors  <= errors + fails;
            pending <= expected_results.size();
        end
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench top for the edge classifier: clock, reset, edge stimulus, result receiver and verdict.
module tb_top;

    localparam int NODES          = 1024;
    localparam int VMAX           = 1023;
    localparam int ITEMS          = 1550;
    localparam int IDLE_PCT       = 15;
    localparam int QUIET_FROM     = 800;
    localparam int QUIET_TO       = 1000;
    localparam int HOLD_EVERY     = 600;
    localparam int HOLD_CYCLES    = 400;
    localparam int CHAIN_AT       = 300;
    localparam int CHAIN_LEN      = 256;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 20000;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  edge_valid   = 1'b0;
    logic                  edge_stall;
    kec_pkg::edge_item_t   edge_item    = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    kec_pkg::result_item_t result_item;
    int                    errors;
    int                    pending;
    int                    items_sent   = 0;
    logic                  quiet        = 1'b0;

    kruskal_edge_classifier_unit #(.NODES(NODES)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .edge_valid   (edge_valid),
        .edge_stall   (edge_stall),
        .edge_item    (edge_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    kec_forest_checker #(.NODES(NODES)) forest_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .edge_valid   (edge_valid),
        .edge_stall   (edge_stall),
        .edge_item    (edge_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .errors       (errors),
        .pending      (pending)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic kec_pkg::edge_item_t edge_of(input logic op, input int a, input int b);
        kec_pkg::edge_item_t it;
        it.func     = op;
        it.vertex_a = kec_pkg::VERTEX_W'(a);
        it.vertex_b = kec_pkg::VERTEX_W'(b);
        return it;
    endfunction

    task automatic send_edge(input kec_pkg::edge_item_t it);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            edge_valid <= 1'b0;
            @(posedge clk);
        end
        edge_valid <= 1'b1;
        edge_item  <= it;
        do
            @(posedge clk);
        while (edge_stall);
        items_sent++;
        quiet = (items_sent >= QUIET_FROM && items_sent < QUIET_TO);
    endtask

    initial
    begin : stimulus
        int   pool [256];
        int   pool_size;
        int   set_len;
        int   base;
        int   a;
        int   b;
        logic chain_done;
        chain_done = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_edge(edge_of(kec_pkg::FUNC_CLASSIFY, 0, VMAX));
        send_edge(edge_of(kec_pkg::FUNC_CLASSIFY, VMAX, 0));
        send_edge(edge_of(kec_pkg::FUNC_CLASSIFY, 5, 5));
        send_edge(edge_of(kec_pkg::FUNC_CLASSIFY, VMAX, VMAX));
        send_edge(edge_of(kec_pkg::FUNC_CLASSIFY, 0, 0));
        send_edge(edge_of(kec_pkg::FUNC_CLASSIFY, 'h2AA, 'h155));
        send_edge(edge_of(kec_pkg::FUNC_CLASSIFY, 'h155, 0));
        for (int i = 0; i < 8; i++)
            send_edge(edge_of(kec_pkg::FUNC_CLASSIFY, 101 + i, 100 + i));
        send_edge(edge_of(kec_pkg::FUNC_CLASSIFY, 100, 108));
        send_edge(edge_of(kec_pkg::FUNC_CLASSIFY, 108, 'h2AA));
        send_edge(edge_of(kec_pkg::FUNC_CLEAR, VMAX, VMAX));
        send_edge(edge_of(kec_pkg::FUNC_CLEAR, 0, 0));
        send_edge(edge_of(kec_pkg::FUNC_CLASSIFY, VMAX, 0));
        send_edge(edge_of(kec_pkg::FUNC_CLASSIFY, 100, 108));

        while (items_sent < ITEMS)
        begin
            if (!chain_done && items_sent >= CHAIN_AT)
            begin
                // Each new vertex becomes the root above the previous one, so the first
                // vertex of the chain ends up at the bottom of a long parent walk.
                send_edge(edge_of(kec_pkg::FUNC_CLEAR, $urandom_range(VMAX),
                                  $urandom_range(VMAX)));
                base = $urandom_range(VMAX);
                for (int i = 1; i < CHAIN_LEN; i++)
                    send_edge(edge_of(kec_pkg::FUNC_CLASSIFY, (base + i) % NODES,
                                      (base + i - 1) % NODES));
                send_edge(edge_of(kec_pkg::FUNC_CLASSIFY, base,
                                  (base + CHAIN_LEN - 1) % NODES));
                send_edge(edge_of(kec_pkg::FUNC_CLASSIFY, base, (base + CHAIN_LEN) % NODES));
                chain_done = 1'b1;
            end
            if ($urandom_range(7) != 0)
                send_edge(edge_of(kec_pkg::FUNC_CLEAR, $urandom_range(VMAX),
                                  $urandom_range(VMAX)));
            pool_size = ($urandom_range(7) == 0) ? $urandom_range(64, 256) : $urandom_range(2, 40);
            for (int i = 0; i < pool_size; i++)
                pool[i] = $urandom_range(VMAX);
            set_len = $urandom_range(pool_size, 2 * pool_size + 4);
            for (int i = 0; i < set_len && items_sent < ITEMS; i++)
            begin
                a = ($urandom_range(19) == 0) ? $urandom_range(VMAX)
                                               : pool[$urandom_range(pool_size - 1)];
                b = ($urandom_range(19) == 0) ? $urandom_range(VMAX)
                                               : pool[$urandom_range(pool_size - 1)];
                send_edge(edge_of(kec_pkg::FUNC_CLASSIFY, a, b));
            end
        end

        edge_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : receiver
        int hold_left;
        int next_hold;
        hold_left = 0;
        next_hold = HOLD_EVERY;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && items_sent >= next_hold)
            begin
                hold_left = HOLD_CYCLES;
                next_hold += HOLD_EVERY;
            end
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else
                result_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((edge_valid && !edge_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
